// ----- hw/rtl/hcs_pkg.sv -----
// ----------------------------------------------------------------------------
// hcs_pkg: shared types, codes and mod-26 helpers
// Constants, status and register codes, and the small arithmetic functions
// used by the key preparation and the block multiply.
// ----------------------------------------------------------------------------
package hcs_pkg;

    localparam int MAX_BLOCK = 3;
    localparam int KEY_W     = 45;

    localparam logic [4:0] PAD_LETTER = 5'd23;   // 'X' - 'A'
    localparam logic [6:0] ASCII_A    = 7'd65;
    localparam logic [7:0] ASCII_UA   = 8'd65;
    localparam logic [7:0] ASCII_UZ   = 8'd90;
    localparam logic [7:0] ASCII_LA   = 8'd97;
    localparam logic [7:0] ASCII_LZ   = 8'd122;

    // key prep pipeline depth, counted from the config write
    localparam logic [2:0] DRV_LAT = 3'd4;

    // entries outside the upper-left 2x2 corner of the 3x3 key
    localparam logic [8:0] OUTER_MASK = 9'b1_1110_0100;

    typedef enum logic [1:0] {
        CFG_KEY   = 2'd0,
        CFG_MODE  = 2'd1,
        CFG_BSIZE = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_KEY  = 2'd1,
        ST_PART = 2'd2
    } t_status;

    typedef struct packed {
        logic [8:0][4:0] mat;   // applied matrix, row major
        logic            bad;   // decrypt with a singular key
        logic            mode;  // 1: decrypt
        logic            n3;    // 3x3 blocks
        logic            busy;  // derived matrix not settled yet
    } t_key_info;

    function automatic logic [9:0] mul5(input logic [4:0] a, input logic [4:0] b);
        mul5 = 10'(a) * 10'(b);
    endfunction

    // x mod 26 for x < 2048: reciprocal estimate, then one correction
    function automatic logic [4:0] mod26(input logic [10:0] x);
        logic [22:0] p;
        logic [10:0] r;
        p = 23'(x) * 23'd2520;
        r = x - 11'(11'(p[22:16]) * 11'd26);
        mod26 = (r >= 11'd26) ? 5'(r - 11'd26) : 5'(r);
    endfunction

    function automatic logic [4:0] red26(input logic [4:0] x);
        red26 = (x >= 5'd26) ? x - 5'd26 : x;
    endfunction

    function automatic logic [4:0] neg26(input logic [4:0] x);
        neg26 = (x == 5'd0) ? 5'd0 : 5'd26 - x;
    endfunction

    // multiplicative inverse mod 26, 0 when none exists
    function automatic logic [4:0] inv26(input logic [4:0] d);
        case (d)
            5'd1:    inv26 = 5'd1;
            5'd3:    inv26 = 5'd9;
            5'd5:    inv26 = 5'd21;
            5'd7:    inv26 = 5'd15;
            5'd9:    inv26 = 5'd3;
            5'd11:   inv26 = 5'd19;
            5'd15:   inv26 = 5'd7;
            5'd17:   inv26 = 5'd23;
            5'd19:   inv26 = 5'd11;
            5'd21:   inv26 = 5'd5;
            5'd23:   inv26 = 5'd17;
            5'd25:   inv26 = 5'd25;
            default: inv26 = 5'd0;
        endcase
    endfunction

endpackage

// ----- hw/rtl/hcs_key_prep.sv -----
// ----------------------------------------------------------------------------
// hcs_key_prep: key matrix preparation
// Reduces the key entries, forms cofactors, determinant and its inverse, and
// registers the matrix applied to each block. Four register stages.
// ----------------------------------------------------------------------------
module hcs_key_prep
    import hcs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [KEY_W-1:0]   i_key,
    input  logic               i_mode,
    input  logic [1:0]         i_bsize,
    output t_key_info          o_info
);

    logic [8:0][4:0] r_k, n_k;
    logic [8:0][4:0] r_cof, n_cof;
    logic [8:0][4:0] r_mat, n_mat;
    logic            r_mode, r_n3, r_bad;
    logic [4:0]      r_invd;
    logic [10:0]     n_det_sum;
    logic [2:0]      r_cnt;

    // stage A: reduced key, masked down to 2x2 when needed
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            if (i_bsize != 2'd3 && OUTER_MASK[i]) begin
                n_k[i] = 5'd0;
            end else begin
                n_k[i] = red26(i_key[5*i +: 5]);
            end
        end
    end

    // stage B: cofactors
    always_comb begin
        int r0, r1, c0, c1;
        logic [4:0] mnr;
        r0    = 0;
        r1    = 0;
        c0    = 0;
        c1    = 0;
        mnr   = 5'd0;
        n_cof = '0;
        if (r_n3) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r0 = (r == 0) ? 1 : 0;
                    r1 = (r == 2) ? 1 : 2;
                    c0 = (c == 0) ? 1 : 0;
                    c1 = (c == 2) ? 1 : 2;
                    mnr = mod26(11'(mul5(r_k[r0*3+c0], r_k[r1*3+c1])) + 11'd676
                                - 11'(mul5(r_k[r0*3+c1], r_k[r1*3+c0])));
                    n_cof[r*3+c] = (((r + c) & 1) == 1) ? neg26(mnr) : mnr;
                end
            end
        end else begin
            n_cof[0] = r_k[4];
            n_cof[1] = neg26(r_k[3]);
            n_cof[3] = neg26(r_k[1]);
            n_cof[4] = r_k[0];
        end
    end

    // stage C: determinant along row 0
    assign n_det_sum = 11'(mul5(r_k[0], r_cof[0])) + 11'(mul5(r_k[1], r_cof[1]))
                     + 11'(mul5(r_k[2], r_cof[2]));

    // stage D: adjugate times inverse determinant, or the key itself
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_mat[r*3+c] = r_mode ? mod26(11'(mul5(r_invd, r_cof[c*3+r])))
                                      : r_k[r*3+c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_cof  <= n_cof;
        r_invd <= inv26(mod26(n_det_sum));
        r_mat  <= n_mat;
        r_bad  <= r_mode && (r_invd == 5'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_n3   <= 1'b0;
            r_cnt  <= DRV_LAT;
        end else begin
            r_mode <= i_mode;
            r_n3   <= (i_bsize == 2'd3);
            if (i_cfg_we) begin
                r_cnt <= DRV_LAT;
            end else if (r_cnt != 3'd0) begin
                r_cnt <= r_cnt - 3'd1;
            end
        end
    end

    assign o_info.mat  = r_mat;
    assign o_info.bad  = r_bad;
    assign o_info.mode = r_mode;
    assign o_info.n3   = r_n3;
    assign o_info.busy = (r_cnt != 3'd0);

endmodule

// ----- hw/rtl/hill_cipher_stream.sv -----
// ----------------------------------------------------------------------------
// hill_cipher_stream: streaming Hill cipher mod 26
// Letters are gathered into blocks of 2 or 3 and multiplied by the key or
// its inverse; results leave as uppercase ASCII, one letter per item.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake            | payload
//  s_axis   | in  | tvalid / tready      | tdata[7:0] char_code, tlast last
//  m_axis   | out | tvalid / tready      | tdata[6:0] letter, tuser status,
//           |     |                      | tlast last_of_run
//  cfg      | in  | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
//  One input item per cycle while s_axis_tready is high. A completed block
//  waits in the job register and is multiplied into the result set; its 2 or
//  3 letters (one for a short decrypt block) leave one a cycle while the
//  sink is ready. Output rate bounds the input while blocks drain, and
//  output stalls back up into s_axis. After reset or any config write,
//  s_axis_tready stays low while key prep settles. Reset: sync, active low.
// ----------------------------------------------------------------------------
module hill_cipher_stream
    import hcs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] char_code
    input  logic               s_axis_tlast,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [7:0]         m_axis_tdata,   // [6:0] letter, [7] zero
    output logic [1:0]         m_axis_tuser,   // [1:0] status
    output logic               m_axis_tlast,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [KEY_W-1:0]   i_cfg_data
);

    t_key_info       w_info;
    logic            w_cfg_we;

    logic [KEY_W-1:0] r_key;
    logic             r_mode;
    logic [1:0]       r_bsize;

    logic [2:0][4:0] r_buf, n_buf;
    logic [1:0]      r_fill, n_fill;

    logic            r_job_vld;
    logic [2:0][4:0] r_job_v;
    logic            r_job_err;
    logic            r_job_n3;

    logic            r_set_vld;
    logic [2:0][4:0] r_res_ltr, n_res_ltr;
    t_status         r_res_st, n_res_st;
    logic [1:0]      r_res_cnt, r_res_idx;

    logic            in_fire, out_fire, set_last, set_free, job_take;
    logic            is_up, is_lo, is_letter, wr, blk, pad_cond, job_new;
    logic [4:0]      val;
    logic [1:0]      fill_w, n_len;

    // configuration
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '0;
            r_mode  <= 1'b0;
            r_bsize <= 2'd2;
        end else if (w_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY:   r_key   <= i_cfg_data;
                CFG_MODE:  r_mode  <= i_cfg_data[0];
                CFG_BSIZE: r_bsize <= i_cfg_data[1:0];
                default:   ;
            endcase
        end
    end

    hcs_key_prep u_key_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_we (w_cfg_we),
        .i_key    (r_key),
        .i_mode   (r_mode),
        .i_bsize  (r_bsize),
        .o_info   (w_info)
    );

    // handshakes
    assign out_fire      = r_set_vld && m_axis_tready;
    assign set_last      = (r_res_idx == r_res_cnt - 2'd1);
    assign set_free      = !r_set_vld || (out_fire && set_last);
    assign job_take      = r_job_vld && set_free;
    assign s_axis_tready = !w_info.busy && (!r_job_vld || job_take);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // letter gathering
    assign is_up     = (s_axis_tdata >= ASCII_UA) && (s_axis_tdata <= ASCII_UZ);
    assign is_lo     = (s_axis_tdata >= ASCII_LA) && (s_axis_tdata <= ASCII_LZ);
    assign is_letter = is_up || is_lo;
    assign val       = is_up ? 5'(s_axis_tdata - ASCII_UA) : 5'(s_axis_tdata - ASCII_LA);
    assign n_len     = w_info.n3 ? 2'd3 : 2'd2;
    assign wr        = is_letter && (r_fill != 2'd3);
    assign fill_w    = wr ? r_fill + 2'd1 : r_fill;
    assign blk       = wr && (fill_w >= n_len);
    assign pad_cond  = s_axis_tlast && !blk && (fill_w != 2'd0) && (fill_w < n_len);
    assign job_new   = blk || pad_cond;

    always_comb begin
        n_buf = r_buf;
        if (wr) begin
            n_buf[r_fill] = val;
        end
        // encrypt pads the short final block with X
        if (pad_cond && !w_info.mode) begin
            for (int i = 0; i < 3; i++) begin
                if (2'(i) >= fill_w) begin
                    n_buf[i] = PAD_LETTER;
                end
            end
        end
        n_fill = (blk || s_axis_tlast) ? 2'd0 : fill_w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf  <= '0;
            r_fill <= 2'd0;
        end else if (in_fire) begin
            r_buf  <= n_buf;
            r_fill <= n_fill;
        end
    end

    // job register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_vld <= 1'b0;
        end else if (in_fire && job_new) begin
            r_job_vld <= 1'b1;
        end else if (job_take) begin
            r_job_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && job_new) begin
            r_job_v   <= n_buf;
            r_job_err <= pad_cond && w_info.mode;
            r_job_n3  <= w_info.n3;
        end
    end

    // block multiply
    always_comb begin
        logic [10:0] s;
        for (int r = 0; r < 3; r++) begin
            s = 11'(mul5(w_info.mat[r*3+0], r_job_v[0]))
              + 11'(mul5(w_info.mat[r*3+1], r_job_v[1]))
              + 11'(mul5(w_info.mat[r*3+2], r_job_v[2]));
            n_res_ltr[r] = (w_info.bad || r_job_err) ? 5'd0 : mod26(s);
        end
        if (w_info.bad) begin
            n_res_st = ST_KEY;
        end else if (r_job_err) begin
            n_res_st = ST_PART;
        end else begin
            n_res_st = ST_OK;
        end
    end

    // result set, drained one letter per cycle while m_axis_tready is high
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_vld <= 1'b0;
            r_res_idx <= 2'd0;
        end else if (job_take) begin
            r_set_vld <= 1'b1;
            r_res_idx <= 2'd0;
        end else if (out_fire) begin
            if (set_last) begin
                r_set_vld <= 1'b0;
            end
            r_res_idx <= r_res_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (job_take) begin
            r_res_ltr <= n_res_ltr;
            r_res_st  <= n_res_st;
            r_res_cnt <= r_job_err ? 2'd1 : (r_job_n3 ? 2'd3 : 2'd2);
        end
    end

    assign m_axis_tvalid = r_set_vld;
    assign m_axis_tdata  = {1'b0, ASCII_A + 7'(r_res_ltr[r_res_idx])};
    assign m_axis_tuser  = r_res_st;
    assign m_axis_tlast  = set_last;

endmodule

// ----- hw/rtl/hcs_checker.sv -----
// ----------------------------------------------------------------------------
// hcs_checker: port-level checks for hill_cipher_stream
// Watches the result stream for legal letters, status codes, stall rules and an idle output after reset.
// ----------------------------------------------------------------------------
module hcs_checker
    import hcs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,
    input  logic [1:0] m_axis_tuser,
    input  logic       m_axis_tlast
);

    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_letter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[6:0] >= 7'd65) && (m_axis_tdata[6:0] <= 7'd90)
                          && !m_axis_tdata[7])
        else $error("letter out of range");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_OK) || (m_axis_tuser == ST_KEY)
                          || (m_axis_tuser == ST_PART))
        else $error("unknown status");

    a_error_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_OK) |-> m_axis_tdata[6:0] == 7'd65)
        else $error("error result carries a letter");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

endmodule

bind hill_cipher_stream hcs_checker u_hcs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ----- sim/hill_cipher_checker.sv -----
// ----------------------------------------------------------------------------
// hill_cipher_checker: result predictor and scoreboard for hill_cipher_stream
// Tracks config writes and accepted input items, computes the expected cipher
// letters with its own mod-26 matrix math, and compares every accepted output
// item against the oldest expected one.
// ----------------------------------------------------------------------------
module hill_cipher_checker
    import hcs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    input  logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,
    input  logic             s_axis_tlast,
    input  logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    input  logic [7:0]       m_axis_tdata,
    input  logic [1:0]       m_axis_tuser,
    input  logic             m_axis_tlast,
    input  logic             i_cfg_valid,
    input  logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [KEY_W-1:0] i_cfg_data,
    output int               o_err_cnt,
    output int               o_pending
);

    typedef struct packed {
        logic [6:0] letter;
        t_status    status;
        logic       last;
    } t_cipher_res;

    logic [KEY_W-1:0] key_reg   = '0;
    logic             mode_reg  = 1'b0;
    logic [1:0]       bsize_reg = 2'd2;
    logic [4:0]       letter_buf [MAX_BLOCK];
    int               fill_cnt  = 0;

    t_cipher_res      cipher_q [$];
    t_cipher_res      step_res [MAX_BLOCK];
    int               step_cnt;
    int               err_cnt   = 0;

    initial begin
        o_err_cnt = 0;
        o_pending = 0;
    end

    function automatic int key_entry(input int r, input int c);
        return int'((key_reg >> (5 * (r * 3 + c))) & 45'h1F) % 26;
    endfunction

    // matrix applied to a block; 0 when decrypting with a singular key
    function automatic bit derive_matrix(input int n, output logic [8:0][4:0] m);
        int k [9];
        int cof [9];
        int det, invd, mnr, r, c, i, r0, r1, c0, c1;
        m = '0;
        for (i = 0; i < 9; i++) begin
            k[i]   = 0;
            cof[i] = 0;
        end
        for (r = 0; r < n; r++)
            for (c = 0; c < n; c++)
                k[r * 3 + c] = key_entry(r, c);
        if (!mode_reg) begin
            for (i = 0; i < 9; i++)
                m[i] = 5'(k[i]);
            return 1'b1;
        end
        if (n == 2) begin
            det    = (k[0] * k[4] + 676 - k[1] * k[3]) % 26;
            cof[0] = k[4];
            cof[1] = (26 - k[3]) % 26;
            cof[3] = (26 - k[1]) % 26;
            cof[4] = k[0];
        end else begin
            for (r = 0; r < 3; r++) begin
                for (c = 0; c < 3; c++) begin
                    r0  = (r == 0) ? 1 : 0;
                    r1  = (r == 2) ? 1 : 2;
                    c0  = (c == 0) ? 1 : 0;
                    c1  = (c == 2) ? 1 : 2;
                    mnr = (k[r0 * 3 + c0] * k[r1 * 3 + c1] + 676
                           - k[r0 * 3 + c1] * k[r1 * 3 + c0]) % 26;
                    cof[r * 3 + c] = ((r + c) % 2 == 1) ? (26 - mnr) % 26 : mnr;
                end
            end
            det = (k[0] * cof[0] + k[1] * cof[1] + k[2] * cof[2]) % 26;
        end
        invd = 0;
        for (i = 1; i < 26; i++)
            if ((det * i) % 26 == 1) invd = i;
        if (invd == 0) return 1'b0;
        // inverse = adjugate (transposed cofactors) times inverse determinant
        for (r = 0; r < n; r++)
            for (c = 0; c < n; c++)
                m[r * 3 + c] = 5'((invd * cof[c * 3 + r]) % 26);
        return 1'b1;
    endfunction

    task automatic add_result(input logic [6:0] ltr, input t_status st);
        step_res[step_cnt] = '{letter: ltr, status: st, last: 1'b0};
        step_cnt++;
    endtask

    task automatic cipher_block(input int n);
        logic [8:0][4:0] m;
        int r, c, s;
        if (!derive_matrix(n, m)) begin
            for (r = 0; r < n; r++)
                add_result(ASCII_A, ST_KEY);
        end else begin
            for (r = 0; r < n; r++) begin
                s = 0;
                for (c = 0; c < n; c++)
                    s += int'(m[r * 3 + c]) * int'(letter_buf[c]);
                add_result(7'(int'(ASCII_A) + s % 26), ST_OK);
            end
        end
    endtask

    task automatic predict_byte(input logic [7:0] ch, input logic lst);
        logic [8:0][4:0] m;
        logic            is_ltr;
        logic [4:0]      val;
        int              n, i;
        n        = (bsize_reg < 2'd2) ? 2 : int'(bsize_reg);
        step_cnt = 0;
        is_ltr   = 1'b0;
        val      = '0;
        if (ch >= ASCII_UA && ch <= ASCII_UZ) begin
            is_ltr = 1'b1;
            val    = 5'(ch - ASCII_UA);
        end else if (ch >= ASCII_LA && ch <= ASCII_LZ) begin
            is_ltr = 1'b1;
            val    = 5'(ch - ASCII_LA);
        end
        if (is_ltr && fill_cnt < MAX_BLOCK) begin
            letter_buf[fill_cnt] = val;
            fill_cnt++;
            // block size may have shrunk while letters were buffered
            if (fill_cnt >= n) begin
                cipher_block(n);
                fill_cnt = 0;
            end
        end
        if (lst) begin
            if (fill_cnt > 0 && fill_cnt < n) begin
                if (!mode_reg) begin
                    for (i = fill_cnt; i < n; i++)
                        letter_buf[i] = PAD_LETTER;
                    cipher_block(n);
                end else begin
                    add_result(ASCII_A, derive_matrix(n, m) ? ST_PART : ST_KEY);
                end
            end
            fill_cnt = 0;
        end
        for (i = 0; i < step_cnt; i++) begin
            if (i == step_cnt - 1) step_res[i].last = 1'b1;
            cipher_q.insert(cipher_q.size(), step_res[i]);
        end
    endtask

    task automatic note_error(input string msg);
        if (err_cnt < 10) $display("%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_cipher_res exp_res;
        if (!i_rst_n) begin
            key_reg   = '0;
            mode_reg  = 1'b0;
            bsize_reg = 2'd2;
            for (int i = 0; i < MAX_BLOCK; i++)
                letter_buf[i] = '0;
            fill_cnt  = 0;
            cipher_q.delete();
        end else begin
            // outputs first: a result never leaves in the cycle its input enters
            if (m_axis_tvalid && m_axis_tready) begin
                if (cipher_q.size() == 0) begin
                    note_error($sformatf("unexpected item: tdata %h tuser %0d tlast %0d",
                                         m_axis_tdata, m_axis_tuser, m_axis_tlast));
                end else begin
                    exp_res = cipher_q.pop_front();
                    if (m_axis_tdata !== {1'b0, exp_res.letter} ||
                        m_axis_tuser !== exp_res.status ||
                        m_axis_tlast !== exp_res.last)
                        note_error($sformatf({"wrong item: letter exp %h got %h, ",
                                              "status exp %0d got %0d, last exp %0d got %0d"},
                                             {1'b0, exp_res.letter}, m_axis_tdata,
                                             exp_res.status, m_axis_tuser,
                                             exp_res.last, m_axis_tlast));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_byte(s_axis_tdata, s_axis_tlast);
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_KEY:   key_reg   = i_cfg_data;
                    CFG_MODE:  mode_reg  = i_cfg_data[0];
                    CFG_BSIZE: bsize_reg = i_cfg_data[1:0];
                    default: ;
                endcase
            end
        end
        o_err_cnt <= err_cnt;
        o_pending <= cipher_q.size();
    end

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench top for hill_cipher_stream
// Drives a directed set of text bytes and key settings, then random messages
// under changing keys, modes and block sizes with random source gaps and sink
// stalls. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import hcs_pkg::*;

    localparam int LIMIT     = 300000;
    localparam int DRAIN_CYC = 12;

    // 2x2 key [[3,3],[2,5]] with junk in the unused outer entries
    localparam logic [KEY_W-1:0] KEY_PAIR =
        {5'd31, 5'd26, 5'd7, 5'd9, 5'd5, 5'd2, 5'd17, 5'd3, 5'd3};
    // invertible 3x3 key [[6,24,1],[13,16,10],[20,17,15]]
    localparam logic [KEY_W-1:0] KEY_TRI =
        {5'd15, 5'd17, 5'd20, 5'd10, 5'd16, 5'd13, 5'd1, 5'd24, 5'd6};
    localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata  = '0;
    logic             s_axis_tlast  = 1'b0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [7:0]       m_axis_tdata;
    logic [1:0]       m_axis_tuser;
    logic             m_axis_tlast;
    logic             i_cfg_valid   = 1'b0;
    logic             o_cfg_ready;
    logic [1:0]       i_cfg_index   = '0;
    logic [KEY_W-1:0] i_cfg_data    = '0;

    int fail_cnt;
    int pending_cnt;
    int gap_pct    = 0;
    int stall_pct  = 0;
    int letter_cnt = 0;
    int cycle_cnt  = 0;

    always #5 i_clk = ~i_clk;

    hill_cipher_stream dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    hill_cipher_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_err_cnt     (fail_cnt),
        .o_pending     (pending_cnt)
    );

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // valid stays high across back-to-back items; dropped only for a gap or by drain()
    task automatic send_byte(input logic [7:0] ch, input logic lst);
        while ($urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= lst;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [KEY_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic cfg_load(input logic [KEY_W-1:0] key, input logic md,
                            input logic [1:0] bsize);
        cfg_write(CFG_KEY, key);
        cfg_write(CFG_MODE, KEY_W'(md));
        cfg_write(CFG_BSIZE, KEY_W'(bsize));
        i_cfg_valid <= 1'b0;
    endtask

    // stop sending, let every expected item out, then let the pipe settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic send_message();
        int len, kind, i;
        logic [7:0] ch;
        len = $urandom_range(14, 1);
        for (i = 0; i < len; i++) begin
            kind = $urandom_range(99);
            if (kind < 45)
                ch = 8'(65 + $urandom_range(25));
            else if (kind < 85)
                ch = 8'(97 + $urandom_range(25));
            else
                ch = 8'($urandom_range(255));
            if (kind < 85) letter_cnt++;
            // occasional early end-of-message marks break the sequence
            send_byte(ch, (i == len - 1) || ($urandom_range(99) < 4));
        end
    endtask

    initial begin
        int ph, phase_start;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: zero key, encrypt, pairs
        send_byte("A", 1'b0);
        send_byte("z", 1'b1);

        drain();
        cfg_load(KEY_PAIR, 1'b0, 2'd2);
        send_byte(8'h00, 1'b0);
        send_byte("H", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte("i", 1'b0);
        send_byte("!", 1'b1);      // end mark with nothing buffered
        send_byte("q", 1'b1);      // padded with X

        drain();
        cfg_load(KEY_PAIR, 1'b1, 2'd2);
        send_byte("a", 1'b0);
        send_byte("b", 1'b0);
        send_byte("c", 1'b1);      // incomplete final block

        drain();
        cfg_load(KEY_ONES, 1'b1, 2'd3);   // singular key
        send_byte("a", 1'b0);
        send_byte("b", 1'b0);
        send_byte("c", 1'b0);
        send_byte("d", 1'b1);

        drain();
        cfg_load(KEY_ONES, 1'b0, 2'd1);   // size below range acts as 2
        send_byte("Z", 1'b0);
        send_byte("a", 1'b1);

        // block size lowered with two letters buffered
        drain();
        cfg_load(KEY_TRI, 1'b0, 2'd3);
        send_byte("G", 1'b0);
        send_byte("Y", 1'b0);
        drain();
        cfg_load(KEY_TRI, 1'b0, 2'd2);
        send_byte("b", 1'b1);

        // mode flipped mid-block
        drain();
        cfg_load(KEY_TRI, 1'b0, 2'd3);
        send_byte("a", 1'b0);
        drain();
        cfg_load(KEY_TRI, 1'b1, 2'd3);
        send_byte("b", 1'b0);
        send_byte("c", 1'b1);

        letter_cnt = 0;
        for (ph = 0; ph < 12; ph++) begin
            drain();
            case (ph % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 83; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 83; end
                default: begin gap_pct = 6; stall_pct = 6; end
            endcase
            cfg_load(45'({$urandom, $urandom}), 1'($urandom_range(1)),
                     2'($urandom_range(3)));
            phase_start = letter_cnt;
            while (letter_cnt - phase_start < 27) send_message();
        end

        drain();
        if (fail_cnt == 0 && pending_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/hcs_pkg.sv
hw/rtl/hcs_key_prep.sv
hw/rtl/hill_cipher_stream.sv
hw/rtl/hcs_checker.sv
sim/hill_cipher_checker.sv
sim/tb.sv
